// ===== rtl/gttt_pkg.sv =====
//------------------------------------------------------------------------------
// gttt_pkg
// shared types and constants of the transaction slot table
//------------------------------------------------------------------------------
`default_nettype none
package gttt_pkg;
  localparam int Slots    = 16;
  localparam int IdxW     = 4;
  localparam int CntW     = 5;
  localparam int TimeBits = 48;
  localparam int DlW      = TimeBits + 1;
  localparam int GenW     = 24;

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_LOOKUP  = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_MATCH   = 3'd3;
  localparam logic [2:0] OP_EXPIRE  = 3'd4;
  localparam logic [2:0] OP_SETTAG  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic             latch;     // capture request
    logic             scan_clr;  // reset scan bests
    logic             scan_step; // examine slot scan_idx
    logic [IdxW-1:0]  scan_idx;
    logic             do_alloc;  // commit alloc into free slot
    logic             do_full;
    logic             do_release;
    logic             do_settag;
    logic             do_expire; // free slot scan_idx
    logic             emit;      // load output register
    logic [1:0]       emit_st;
    logic             emit_slot; // report a slot
    logic [IdxW-1:0]  emit_idx;
    logic             emit_cnt;  // report expired count
    logic             emit_last;
  } gttt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0]      opcode;
    logic            res_ok;
    logic [IdxW-1:0] res_idx;
    logic            free_ok;
    logic [IdxW-1:0] free_idx;
    logic            overdue;   // slot scan_idx busy and due
    logic            tag_hit;
    logic [IdxW-1:0] tag_idx;
    logic            best_ok;
    logic [IdxW-1:0] best_idx;
  } gttt_sts_t;
endpackage
`default_nettype wire

// ===== rtl/generation_tagged_transaction_table_top.sv =====
//------------------------------------------------------------------------------
// generation_tagged_transaction_table_top
// 16-slot in-flight transaction table with generation-tagged handles
//------------------------------------------------------------------------------
// usage:
//   in_* carries one request (alloc, lookup, release, match, expire, set tag)
//   under valid/ready; out_* returns results under valid/ready, out_last
//   marking the final result of a request.
//   every request first walks the 16 slots one per cycle, then emits:
//   one result for every request but expire; expire gives one result
//   per overdue slot plus a final count result. a new request is taken
//   only after the previous one has emitted its last result.
//   the slot walk goes through a single compare unit.
//   reset empties every slot, sets the generation counter to one and
//   clears peak occupancy and the rejection count.
//   while out_ready is low the pending result is held and the sequencer
//   waits; no result is dropped.
//------------------------------------------------------------------------------
`default_nettype none
module generation_tagged_transaction_table_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [31:0] in_handle,
  input  wire logic [3:0]  in_txn_kind,
  input  wire logic [15:0] in_short_addr,
  input  wire logic [7:0]  in_endpoint,
  input  wire logic        in_endpoint_valid,
  input  wire logic [7:0]  in_seq_tag,
  input  wire logic        in_seq_tag_valid,
  input  wire logic [47:0] in_now_time,
  input  wire logic [31:0] in_timeout,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_handle,
  output logic [3:0]       out_kind,
  output logic [15:0]      out_short_addr,
  output logic [7:0]       out_endpoint,
  output logic [7:0]       out_seq_tag,
  output logic [48:0]      out_deadline,
  output logic [4:0]       out_expired_count,
  output logic [4:0]       out_in_use_count,
  output logic [4:0]       out_peak_count,
  output logic [31:0]      out_rejections,
  output logic             out_last
);
  import gttt_pkg::*;

  gttt_cmd_t cmd;
  gttt_sts_t sts;
  logic      out_busy;

  gttt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_busy, .cmd, .sts
  );

  gttt_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_opcode, .in_handle, .in_txn_kind, .in_short_addr, .in_endpoint,
    .in_endpoint_valid, .in_seq_tag, .in_seq_tag_valid, .in_now_time, .in_timeout,
    .out_valid, .out_ready, .out_busy, .out_status, .out_handle, .out_kind,
    .out_short_addr, .out_endpoint, .out_seq_tag, .out_deadline,
    .out_expired_count, .out_in_use_count, .out_peak_count, .out_rejections,
    .out_last
  );
endmodule
`default_nettype wire

// ===== rtl/gttt_ctrl.sv =====
//------------------------------------------------------------------------------
// gttt_ctrl
// sequencer: accept, scan slots, emit results
//------------------------------------------------------------------------------
`default_nettype none
module gttt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              out_busy,
  output gttt_pkg::gttt_cmd_t    cmd,
  input  wire gttt_pkg::gttt_sts_t sts
);
  import gttt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_EXP, S_EXPFIN, S_WAIT} state_t;
  state_t state_r;
  logic [IdxW-1:0] idx_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.scan_idx = idx_r;
    cmd.emit_idx = idx_r;
    case (state_r)
      S_IDLE: begin
        cmd.latch = in_valid;
        cmd.scan_clr = in_valid;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_EXEC: if (!out_busy) begin
        cmd.emit = 1'b1;
        cmd.emit_last = 1'b1;
        case (sts.opcode)
          OP_ALLOC: begin
            if (sts.free_ok) begin
              cmd.do_alloc = 1'b1; cmd.emit_st = ST_OK;
              cmd.emit_slot = 1'b1; cmd.emit_idx = sts.free_idx;
            end else begin
              cmd.do_full = 1'b1; cmd.emit_st = ST_FULL;
            end
          end
          OP_LOOKUP, OP_RELEASE, OP_SETTAG: begin
            cmd.emit_st = sts.res_ok ? ST_OK : ST_NONE;
            cmd.emit_slot = sts.res_ok;
            cmd.emit_idx = sts.res_idx;
            cmd.do_release = sts.res_ok && (sts.opcode == OP_RELEASE);
            cmd.do_settag = sts.res_ok && (sts.opcode == OP_SETTAG);
          end
          OP_MATCH: begin
            cmd.emit_slot = sts.tag_hit || sts.best_ok;
            cmd.emit_st = cmd.emit_slot ? ST_OK : ST_NONE;
            cmd.emit_idx = sts.tag_hit ? sts.tag_idx : sts.best_idx;
          end
          default: cmd.emit_st = ST_NONE;
        endcase
      end
      S_EXP: if (!out_busy && sts.overdue) begin
        cmd.do_expire = 1'b1;
        cmd.emit = 1'b1;
        cmd.emit_st = ST_OK;
        cmd.emit_slot = 1'b1;
      end
      S_EXPFIN: if (!out_busy) begin
        cmd.emit = 1'b1;
        cmd.emit_st = ST_OK;
        cmd.emit_cnt = 1'b1;
        cmd.emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) begin
          state_r <= S_SCAN;
          idx_r <= '0;
        end
        S_SCAN: begin
          // index wraps back to zero after the last slot
          idx_r <= idx_r + 1'b1;
          if (idx_r == IdxW'(Slots - 1)) begin
            state_r <= (sts.opcode == OP_EXPIRE) ? S_EXP : S_EXEC;
          end
        end
        S_EXEC: if (!out_busy) state_r <= S_WAIT;
        S_EXP: if (!sts.overdue || !out_busy) begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == IdxW'(Slots - 1)) state_r <= S_EXPFIN;
        end
        S_EXPFIN: if (!out_busy) state_r <= S_WAIT;
        S_WAIT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/gttt_dp.sv =====
//------------------------------------------------------------------------------
// gttt_dp
// slot storage, scan bests, counters and output register
//------------------------------------------------------------------------------
`default_nettype none
module gttt_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire gttt_pkg::gttt_cmd_t   cmd,
  output gttt_pkg::gttt_sts_t        sts,
  input  wire logic [2:0]            in_opcode,
  input  wire logic [31:0]           in_handle,
  input  wire logic [3:0]            in_txn_kind,
  input  wire logic [15:0]           in_short_addr,
  input  wire logic [7:0]            in_endpoint,
  input  wire logic                  in_endpoint_valid,
  input  wire logic [7:0]            in_seq_tag,
  input  wire logic                  in_seq_tag_valid,
  input  wire logic [47:0]           in_now_time,
  input  wire logic [31:0]           in_timeout,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_busy,
  output logic [1:0]                 out_status,
  output logic [31:0]                out_handle,
  output logic [3:0]                 out_kind,
  output logic [15:0]                out_short_addr,
  output logic [7:0]                 out_endpoint,
  output logic [7:0]                 out_seq_tag,
  output logic [48:0]                out_deadline,
  output logic [4:0]                 out_expired_count,
  output logic [4:0]                 out_in_use_count,
  output logic [4:0]                 out_peak_count,
  output logic [31:0]                out_rejections,
  output logic                       out_last
);
  import gttt_pkg::*;

  logic [Slots-1:0]    busy_r, tagk_r;
  logic [GenW-1:0]     gen_r  [Slots];
  logic [3:0]          kind_r [Slots];
  logic [15:0]         addr_r [Slots];
  logic [7:0]          ep_r   [Slots];
  logic [DlW-1:0]      dl_r   [Slots];
  logic [7:0]          tag_r  [Slots];
  logic [GenW-1:0]     gcnt_r;
  logic [CntW-1:0]     peak_r, used_r, expc_r;
  logic [31:0]         full_r;

  // request
  logic [2:0]  op_r;
  logic [31:0] h_r;
  logic [3:0]  kind_q_r;
  logic [15:0] addr_q_r;
  logic [7:0]  ep_q_r, tag_q_r;
  logic        epv_r, tagv_r;
  logic [TimeBits-1:0] now_r;
  logic [DlW-1:0] newdl_r;

  // scan bests
  logic            free_ok_r, tag_hit_r, any_ok_r, epb_ok_r;
  logic [IdxW-1:0] free_idx_r, tag_idx_r, any_idx_r, epb_idx_r;
  logic [DlW-1:0]  any_dl_r, epb_dl_r;

  logic [IdxW-1:0] i;
  logic            cand, tagk_hit;
  assign i = cmd.scan_idx;

  // handle decode
  logic [7:0] low;
  logic       res_ok;
  logic [IdxW-1:0] res_idx;
  always_comb begin
    low = h_r[7:0];
    res_idx = IdxW'(low - 8'd1);
    res_ok = (low != 8'd0) && ({1'b0, low} - 9'd1 < 9'(Slots)) &&
             busy_r[res_idx] && (gen_r[res_idx] == h_r[31:8]);
  end

  always_comb begin
    cand = busy_r[i] && kind_r[i] == kind_q_r && addr_r[i] == addr_q_r;
    tagk_hit = tagv_r && tagk_r[i];
  end

  assign sts.opcode   = op_r;
  assign sts.res_ok   = res_ok;
  assign sts.res_idx  = res_idx;
  assign sts.free_ok  = free_ok_r;
  assign sts.free_idx = free_idx_r;
  assign sts.overdue  = busy_r[i] && (dl_r[i] <= {1'b0, now_r});
  assign sts.tag_hit  = tag_hit_r;
  assign sts.tag_idx  = tag_idx_r;
  assign sts.best_ok  = epb_ok_r || any_ok_r;
  assign sts.best_idx = epb_ok_r ? epb_idx_r : any_idx_r;

  assign out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_opcode; h_r <= in_handle; kind_q_r <= in_txn_kind;
      addr_q_r <= in_short_addr; ep_q_r <= in_endpoint; epv_r <= in_endpoint_valid;
      tag_q_r <= in_seq_tag; tagv_r <= in_seq_tag_valid;
      now_r <= in_now_time[TimeBits-1:0];
      newdl_r <= DlW'({1'b0, in_now_time[TimeBits-1:0]}) + DlW'(in_timeout);
    end
    if (cmd.scan_step) begin
      if (!busy_r[i] && !free_ok_r) begin
        free_ok_r <= 1'b1; free_idx_r <= i;
      end
      if (cand && !tag_hit_r) begin
        if (tagk_hit) begin
          if (tag_r[i] == tag_q_r) begin
            tag_hit_r <= 1'b1; tag_idx_r <= i;
          end
        end else begin
          if (!any_ok_r || dl_r[i] < any_dl_r) begin
            any_ok_r <= 1'b1; any_idx_r <= i; any_dl_r <= dl_r[i];
          end
          if (epv_r && ep_r[i] == ep_q_r && (!epb_ok_r || dl_r[i] < epb_dl_r)) begin
            epb_ok_r <= 1'b1; epb_idx_r <= i; epb_dl_r <= dl_r[i];
          end
        end
      end
    end
    if (cmd.scan_clr) begin
      free_ok_r <= 1'b0; tag_hit_r <= 1'b0; any_ok_r <= 1'b0; epb_ok_r <= 1'b0;
      free_idx_r <= '0; tag_idx_r <= '0; any_idx_r <= '0; epb_idx_r <= '0;
      any_dl_r <= '0; epb_dl_r <= '0;
    end
    if (!rst_n) begin
      for (int k = 0; k < Slots; k++) begin
        gen_r[k] <= '0; kind_r[k] <= '0; addr_r[k] <= '0;
        ep_r[k] <= '0; dl_r[k] <= '0; tag_r[k] <= '0;
      end
    end else begin
      if (cmd.do_alloc) begin
        gen_r[free_idx_r] <= gcnt_r; kind_r[free_idx_r] <= kind_q_r;
        addr_r[free_idx_r] <= addr_q_r; ep_r[free_idx_r] <= ep_q_r;
        dl_r[free_idx_r] <= newdl_r; tag_r[free_idx_r] <= '0;
      end
      if (cmd.do_settag) tag_r[res_idx] <= tag_q_r;
    end
  end

  // in-use count after this command's update, as the result reports it
  logic [CntW-1:0] used_nxt;
  always_comb begin
    used_nxt = used_r;
    if (cmd.do_alloc) used_nxt = used_r + 1'b1;
    if (cmd.do_release || cmd.do_expire) used_nxt = used_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0; tagk_r <= '0; gcnt_r <= GenW'(1); peak_r <= '0;
      full_r <= '0; used_r <= '0; expc_r <= '0; out_valid <= 1'b0;
    end else begin
      used_r <= used_nxt;
      if (cmd.latch) expc_r <= '0;
      if (cmd.do_alloc) begin
        busy_r[free_idx_r] <= 1'b1; tagk_r[free_idx_r] <= 1'b0;
        gcnt_r <= gcnt_r + 1'b1;
        if (used_nxt > peak_r) peak_r <= used_nxt;
      end
      if (cmd.do_full) full_r <= full_r + 32'd1;
      if (cmd.do_release) busy_r[res_idx] <= 1'b0;
      if (cmd.do_settag) tagk_r[res_idx] <= 1'b1;
      if (cmd.do_expire) begin
        busy_r[i] <= 1'b0; expc_r <= expc_r + 1'b1;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.emit_st;
      out_last <= cmd.emit_last;
      out_expired_count <= cmd.emit_cnt ? expc_r : '0;
      out_in_use_count <= used_nxt;
      out_peak_count <= (cmd.do_alloc && used_nxt > peak_r) ? used_nxt : peak_r;
      out_rejections <= cmd.do_full ? full_r + 32'd1 : full_r;
      if (cmd.emit_slot) begin
        out_handle <= {cmd.do_alloc ? gcnt_r : gen_r[cmd.emit_idx],
                       8'({1'b0, cmd.emit_idx} + 5'd1)};
        out_kind <= cmd.do_alloc ? kind_q_r : kind_r[cmd.emit_idx];
        out_short_addr <= cmd.do_alloc ? addr_q_r : addr_r[cmd.emit_idx];
        out_endpoint <= cmd.do_alloc ? ep_q_r : ep_r[cmd.emit_idx];
        out_seq_tag <= cmd.do_alloc ? 8'd0 :
                       (cmd.do_settag ? tag_q_r : tag_r[cmd.emit_idx]);
        out_deadline <= cmd.do_alloc ? newdl_r : dl_r[cmd.emit_idx];
      end else begin
        out_handle <= '0; out_kind <= '0; out_short_addr <= '0;
        out_endpoint <= '0; out_seq_tag <= '0; out_deadline <= '0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/gttt_checker.sv =====
//------------------------------------------------------------------------------
// gttt_checker
// port-level checks of the transaction table
//------------------------------------------------------------------------------
`default_nettype none
module gttt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_handle,
  input wire logic [4:0]  out_in_use_count,
  input wire logic [4:0]  out_peak_count,
  input wire logic        out_last
);
  // held result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_handle))
    else $error("result changed under stall");

  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_in_use_count <= out_peak_count && out_peak_count <= 5'd16)
    else $error("occupancy beyond peak");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == 2'd2 |-> out_handle == 32'd0 && out_last)
    else $error("full result carries a handle");

  // one transaction in the sequencer at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accept");
endmodule

bind generation_tagged_transaction_table_top gttt_checker u_gttt_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_status,
  .out_handle, .out_in_use_count, .out_peak_count, .out_last
);
`default_nettype wire
